>>> rtl/fir46_pkg.sv
package fir46_pkg;

    localparam int TAPS        = 46;
    localparam int COEF_BITS   = 16;
    localparam int SAMPLE_BITS = 12;
    localparam int BASE_TAPS   = 46;

    localparam int TAP_IDX_BITS = $clog2(TAPS);
    localparam int FILL_BITS    = $clog2(TAPS + 1);
    localparam int PROD_BITS    = COEF_BITS + SAMPLE_BITS + 1;
    localparam int ACC_BITS     = PROD_BITS + $clog2(TAPS);
    localparam int SCALE_SHIFT  = COEF_BITS - 1;
    localparam int OUT_BITS     = 13;

    localparam logic signed [OUT_BITS-1:0] OUT_MAX = OUT_BITS'(4095);
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = OUT_BITS'(-4096);

    // rescale of the Q1.15 taps to COEF_BITS-1 fraction bits
    localparam int COEF_UP = (COEF_BITS >= 16) ? COEF_BITS - 16 : 0;
    localparam int COEF_DN = (COEF_BITS < 16) ? 16 - COEF_BITS : 0;
    localparam int COEF_HALF = (COEF_DN > 0) ? (1 << COEF_DN) / 2 : 0;

    // symmetric taps in Q1.15
    localparam int Q15_TAPS [BASE_TAPS] = '{
        608, 793, 910, 941, 875, 714, 469, 161,
        -181, -521, -825, -1057, -1191, -1209, -1106, -888,
        -575, -198, 206, 595, 929, 1173, 1302,
        1302, 1173, 929, 595, 206, -198, -575,
        -888, -1106, -1209, -1191, -1057, -825, -521, -181,
        161, 469, 714, 875, 941, 910, 793, 608
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    // one delayed sample on its way to the multiplier
    typedef struct packed {
        logic                    valid;
        logic                    live;
        logic [TAP_IDX_BITS-1:0] idx;
        logic [SAMPLE_BITS-1:0]  data;
    } t_tap;

    function automatic logic signed [COEF_BITS-1:0] tap_coef(
        input logic [TAP_IDX_BITS-1:0] idx
    );
        int q;
        int r;
        q = 0;
        if (int'(idx) < BASE_TAPS) begin
            q = Q15_TAPS[int'(idx)];
        end
        if (COEF_BITS >= 16) begin
            r = q <<< COEF_UP;
        end else if (q >= 0) begin
            r = (q + COEF_HALF) >>> COEF_DN;
        end else begin
            r = -((-q + COEF_HALF) >>> COEF_DN);
        end
        return COEF_BITS'(r);
    endfunction

endpackage

>>> rtl/fir_filter_46_tap.sv
// Channel   Direction  Valid             Stall              Payload
// sample    in         i_sample_valid    o_sample_stall     i_sample (12 b unsigned)
// filtered  out        o_filtered_valid  i_filtered_stall   o_filtered (13 b signed),
//                                                           o_clipped
//
// One word runs from acceptance to a loaded result as follows: TAPS (46)
// tap reads into one shared multiply-accumulate, one tap read per cycle,
// then a drain of the read and multiply stages, then scale, saturate and load.
// The input stalls for the whole pass, so a word is taken only after the last is loaded.
// Reset zeroes the fill count; taps not yet written read as zero.
// A held result does not block the next sample; only the load waits on it.
module fir_filter_46_tap (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_sample_valid,
    output logic                                   o_sample_stall,
    input  logic [fir46_pkg::SAMPLE_BITS-1:0]      i_sample,
    output logic                                   o_filtered_valid,
    input  logic                                   i_filtered_stall,
    output logic signed [fir46_pkg::OUT_BITS-1:0]  o_filtered,
    output logic                                   o_clipped
);
    import fir46_pkg::*;

    t_state                      r_state, n_state;
    logic                        push;
    logic                        rd_en;
    logic                        load;
    logic                        last;
    logic                        mac_busy;
    t_tap                        tap;
    logic signed [OUT_BITS-1:0]  mac_filtered;
    logic                        mac_clipped;
    logic                        r_out_valid;
    logic signed [OUT_BITS-1:0]  r_filtered;
    logic                        r_clipped;

    fir46_dline u_dline (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (i_sample),
        .i_rd_en  (rd_en),
        .o_last   (last),
        .o_tap    (tap)
    );

    fir46_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (push),
        .i_tap      (tap),
        .o_busy     (mac_busy),
        .o_filtered (mac_filtered),
        .o_clipped  (mac_clipped)
    );

    assign o_sample_stall   = (r_state != S_IDLE);
    assign o_filtered_valid = r_out_valid;
    assign o_filtered       = r_filtered;
    assign o_clipped        = r_clipped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        push    = 1'b0;
        rd_en   = 1'b0;
        load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // write the sample and clear the accumulator
                if (i_sample_valid) begin
                    push    = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // one tap per cycle, newest first
                rd_en = 1'b1;
                if (last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // wait for the read and multiply stages to empty
                if (!tap.valid && !mac_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register frees up
                if (!r_out_valid || !i_filtered_stall) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_filtered <= mac_filtered;
            r_clipped  <= mac_clipped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_filtered_stall) begin
            // drop the word once taken
            r_out_valid <= 1'b0;
        end
    end

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_valid && !o_sample_stall) |=> (r_state == S_RUN))
        else $error("accepted word did not start the tap sweep");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!tap.valid && !mac_busy))
        else $error("multiply pipeline busy while idle");

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_filtered_valid && o_clipped) |-> (o_filtered == OUT_MAX || o_filtered == OUT_MIN))
        else $error("clipped word not at a range limit");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_filtered_valid && r_state == S_IDLE))
        else $error("loaded result not presented");

endmodule

>>> rtl/fir46_dline.sv
module fir46_dline (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [fir46_pkg::SAMPLE_BITS-1:0]  i_sample,
    input  logic                               i_rd_en,
    output logic                               o_last,
    output fir46_pkg::t_tap                    o_tap
);
    import fir46_pkg::*;

    logic [SAMPLE_BITS-1:0]  mem [TAPS];
    logic [TAP_IDX_BITS-1:0] r_wp, n_wp;
    logic [TAP_IDX_BITS-1:0] r_rp;
    logic [TAP_IDX_BITS-1:0] r_k;
    logic [FILL_BITS-1:0]    r_fill;
    logic                    r_tap_valid;
    logic                    r_tap_live;
    logic [TAP_IDX_BITS-1:0] r_tap_idx;
    logic [SAMPLE_BITS-1:0]  r_tap_data;

    assign n_wp   = (r_wp == TAP_IDX_BITS'(TAPS - 1)) ? '0 : r_wp + 1'b1;
    assign o_last = i_rd_en && (r_k == TAP_IDX_BITS'(TAPS - 1));
    assign o_tap  = '{valid: r_tap_valid, live: r_tap_live, idx: r_tap_idx, data: r_tap_data};

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[n_wp] <= i_sample;
        end
        if (i_rd_en) begin
            r_tap_data <= mem[r_rp];
            r_tap_idx  <= r_k;
            // entries past the fill count are marked not live and multiply as zero
            r_tap_live <= (FILL_BITS'(r_k) < r_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_k         <= '0;
            r_fill      <= '0;
            r_tap_valid <= 1'b0;
        end else begin
            r_tap_valid <= i_rd_en;
            if (i_push) begin
                r_wp <= n_wp;
                r_rp <= n_wp;
                r_k  <= '0;
                if (r_fill != FILL_BITS'(TAPS)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (i_rd_en) begin
                // walk from newest to oldest
                r_rp <= (r_rp == '0) ? TAP_IDX_BITS'(TAPS - 1) : r_rp - 1'b1;
                r_k  <= r_k + 1'b1;
            end
        end
    end

endmodule

>>> rtl/fir46_mac.sv
module fir46_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_clear,
    input  fir46_pkg::t_tap                        i_tap,
    output logic                                   o_busy,
    output logic signed [fir46_pkg::OUT_BITS-1:0]  o_filtered,
    output logic                                   o_clipped
);
    import fir46_pkg::*;

    localparam logic signed [ACC_BITS-1:0] BIAS = ACC_BITS'((1 << SCALE_SHIFT) - 1);
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = ACC_BITS'(OUT_MAX);
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = ACC_BITS'(OUT_MIN);

    logic                          r_prod_valid;
    logic signed [PROD_BITS-1:0]   r_prod, n_prod;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic signed [COEF_BITS-1:0]   coef;
    logic signed [PROD_BITS-1:0]   sx;
    logic signed [ACC_BITS-1:0]    biased;
    logic signed [ACC_BITS-1:0]    scaled;

    assign coef   = tap_coef(i_tap.idx);
    assign sx     = i_tap.live ? signed'({{(PROD_BITS - SAMPLE_BITS){1'b0}}, i_tap.data})
                               : '0;
    assign n_prod = PROD_BITS'(coef) * sx;
    assign o_busy = r_prod_valid;

    always_ff @(posedge i_clk) begin
        if (i_tap.valid) begin
            r_prod <= n_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_acc        <= '0;
        end else begin
            r_prod_valid <= i_tap.valid;
            if (i_clear) begin
                r_acc <= '0;
            end else if (r_prod_valid) begin
                r_acc <= r_acc + ACC_BITS'(r_prod);
            end
        end
    end

    // truncate toward zero, then saturate
    always_comb begin
        biased = r_acc[ACC_BITS-1] ? r_acc + BIAS : r_acc;
        scaled = biased >>> SCALE_SHIFT;
        if (scaled > ACC_MAX) begin
            o_filtered = OUT_MAX;
            o_clipped  = 1'b1;
        end else if (scaled < ACC_MIN) begin
            o_filtered = OUT_MIN;
            o_clipped  = 1'b1;
        end else begin
            o_filtered = OUT_BITS'(scaled);
            o_clipped  = 1'b0;
        end
    end

endmodule
